// ----- design/ilst_pkg.sv -----
// Shared codes, widths and types of the indexed insert and remove list.
package ilst_pkg;

   localparam int DEFAULT_CAPACITY     = 16;
   localparam int DEFAULT_ELEMENT_BITS = 32;

   localparam int OPERATION_BITS = 2;
   localparam int POSITION_BITS  = 5;
   localparam int VALUE_BITS     = 32;
   localparam int READ_BITS      = 32;
   localparam int COUNT_BITS     = 5;
   localparam int STATUS_BITS    = 2;

   localparam logic [OPERATION_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OPERATION_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPERATION_BITS-1:0] OP_READ   = 2'd2;
   localparam logic [OPERATION_BITS-1:0] OP_MODIFY = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic insert;
      logic remove;
      logic modify;
   } cell_cmd_type;

endpackage

// ----- design/ilst_cell.sv -----
// One storage cell of the list: holds, loads or takes a neighbor's entry.
module ilst_cell
   import ilst_pkg::*;
#(
   parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS,
   parameter int CW           = 5,
   parameter int CELL_INDEX   = 0
) (
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic [CW-1:0]           position,
   input  logic [ELEMENT_BITS-1:0] value,
   input  logic [ELEMENT_BITS-1:0] left_data,
   input  logic [ELEMENT_BITS-1:0] right_data,
   output logic [ELEMENT_BITS-1:0] data_out,
   output logic [ELEMENT_BITS-1:0] read_out
);

   localparam logic [CW-1:0] MY_INDEX = CW'(CELL_INDEX);

   logic [ELEMENT_BITS-1:0] entry_ff;
   logic [ELEMENT_BITS-1:0] entry_in;
   logic                    selected;
   logic                    above;

   assign selected = (position == MY_INDEX);
   assign above    = (position < MY_INDEX);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (selected) begin
            entry_in = value;
         end else if (above) begin
            entry_in = left_data;
         end
      end else if (cmd.remove) begin
         if (selected || above) begin
            entry_in = right_data;
         end
      end else if (cmd.modify) begin
         if (selected) begin
            entry_in = value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;
   assign read_out = selected ? entry_ff : '0;

endmodule

// ----- design/indexed_insert_remove_list.sv -----
// Top level of the indexed insert and remove list built from a row of cells.
//
// Each request transaction carries one operation in req_tuser (insert, remove,
// read or modify) with a position and a value in req_tdata. Every request
// produces exactly one response transaction carrying the data read, the entry
// count afterwards, an empty flag and a status code.
// The list lives in a row of CAPACITY cells. On an accepted request every cell
// decides in the same cycle whether to hold, load the value, take its lower
// neighbor's entry (insert) or take its upper neighbor's entry (remove).
// The response appears in an output register in the cycle after acceptance.
// A new request is accepted every cycle while the response register is empty
// or being drained, so throughput is one transaction per cycle; the limit is
// the single response register.
// If the receiver stalls, the response is held and req_tready drops until it
// is taken. A bad position, or an insert into a full list, changes nothing.
// Reset empties the list and the response register; entries need no clearing.
module indexed_insert_remove_list
   import ilst_pkg::*;
#(
   parameter int CAPACITY     = DEFAULT_CAPACITY,
   parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position [4:0], value [36:5], zero fill [39:37]
   input  logic [1:0]  req_tuser,   // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_data [31:0], count [36:32], is_empty [37],
                                    // status [39:38]
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POSITION_BITS) ? CW : POSITION_BITS;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [39:0]               rsp_data_ff;
   logic [39:0]               rsp_data_in;

   logic [OPERATION_BITS-1:0] req_operation;
   logic [POSITION_BITS-1:0]  req_position;
   logic [VALUE_BITS-1:0]     req_value;
   logic                      accept;
   logic [XW-1:0]             position_x;
   logic [XW-1:0]             count_x;
   logic                      range_bad;
   logic                      is_insert;
   logic [STATUS_BITS-1:0]    status;
   logic                      good;
   cell_cmd_type              cmd;
   logic [CW-1:0]             cell_position;
   logic [ELEMENT_BITS-1:0]   store_value;
   logic [ELEMENT_BITS-1:0]   read_word;
   logic [READ_BITS-1:0]      read_data;

   logic [ELEMENT_BITS-1:0]   cell_data [CAPACITY];
   logic [ELEMENT_BITS-1:0]   cell_read [CAPACITY];

   assign req_operation = req_tuser;
   assign req_position  = req_tdata[4:0];
   assign req_value     = req_tdata[36:5];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign position_x = XW'(req_position);
   assign count_x    = XW'(count_ff);
   assign is_insert  = (req_operation == OP_INSERT);
   assign range_bad  = is_insert ? (position_x > count_x) : (position_x >= count_x);

   always_comb begin
      if (range_bad) begin
         status = ST_RANGE;
      end else if (is_insert && (count_ff == FULL_COUNT)) begin
         status = ST_FULL;
      end else begin
         status = ST_OK;
      end
   end

   assign good          = accept && (status == ST_OK);
   assign cmd.insert    = good && (req_operation == OP_INSERT);
   assign cmd.remove    = good && (req_operation == OP_REMOVE);
   assign cmd.modify    = good && (req_operation == OP_MODIFY);
   assign cell_position = CW'(req_position);
   assign store_value   = ELEMENT_BITS'(req_value);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEMENT_BITS-1:0] left_data;
      logic [ELEMENT_BITS-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      ilst_cell #(
         .ELEMENT_BITS(ELEMENT_BITS),
         .CW          (CW),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .position  (cell_position),
         .value     (store_value),
         .left_data (left_data),
         .right_data(right_data),
         .data_out  (cell_data[i]),
         .read_out  (cell_read[i])
      );
   end

   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_read[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      case (1'b1)
         cmd.insert: count_in = count_ff + CW'(1);
         cmd.remove: count_in = count_ff - CW'(1);
         default:    count_in = count_ff;
      endcase
   end

   assign read_data = (good && (req_operation == OP_READ)) ? READ_BITS'(read_word) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {status, (count_in == '0), COUNT_BITS'(count_in), read_data};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("Accepted insert did not grow the count by one.");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("Accepted remove did not shrink the count by one.");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && (status != ST_OK)) |=> $stable(count_ff))
      else $error("Rejected request changed the count.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("Request accepted while the response register was stalled.");

endmodule
